@@ design/icd_pkg.sv @@
package icd_pkg;

  // Format class codes
  typedef logic [4:0] inst_class_t;
  typedef logic [3:0] cond_code_t;

  // 32-bit set
  localparam inst_class_t ClsBx        = 5'd0;
  localparam inst_class_t ClsMul       = 5'd1;
  localparam inst_class_t ClsSwp       = 5'd2;
  localparam inst_class_t ClsMull      = 5'd3;
  localparam inst_class_t ClsHalfXfer  = 5'd4;
  localparam inst_class_t ClsDataProc  = 5'd5;
  localparam inst_class_t ClsSingleXfer = 5'd6;
  localparam inst_class_t ClsBranch    = 5'd7;
  localparam inst_class_t ClsBlockXfer = 5'd8;
  localparam inst_class_t ClsSwi       = 5'd9;

  // 16-bit set
  localparam inst_class_t ClsTMovShift  = 5'd10;
  localparam inst_class_t ClsTAddSub    = 5'd11;
  localparam inst_class_t ClsTImm       = 5'd12;
  localparam inst_class_t ClsTAlu       = 5'd13;
  localparam inst_class_t ClsTHiReg     = 5'd14;
  localparam inst_class_t ClsTPcLoad    = 5'd15;
  localparam inst_class_t ClsTRegOff    = 5'd16;
  localparam inst_class_t ClsTSignExt   = 5'd17;
  localparam inst_class_t ClsTImmOff    = 5'd18;
  localparam inst_class_t ClsTHalf      = 5'd19;
  localparam inst_class_t ClsTSpRel     = 5'd20;
  localparam inst_class_t ClsTLoadAddr  = 5'd21;
  localparam inst_class_t ClsTSpAdd     = 5'd22;
  localparam inst_class_t ClsTPushPop   = 5'd23;
  localparam inst_class_t ClsTMultiple  = 5'd24;
  localparam inst_class_t ClsTCondBr    = 5'd25;
  localparam inst_class_t ClsTSwi       = 5'd26;
  localparam inst_class_t ClsTBranch    = 5'd27;
  localparam inst_class_t ClsTLongBr    = 5'd28;

  localparam inst_class_t ClsBubble     = 5'd29;

  localparam cond_code_t CondAlways = 4'd14;

  // Bit patterns
  localparam logic [23:0] BxPattern   = 24'h12fff1;
  localparam logic [3:0]  MulNibble   = 4'h9;
  localparam logic [2:0]  SwpOp       = 3'h2;
  localparam logic [2:0]  MullOp      = 3'h1;

endpackage

@@ design/icd_decode.sv @@
module icd_decode (
  input  logic [31:0]              instruction_i,
  input  logic                     thumb_mode_i,
  output icd_pkg::inst_class_t     inst_class_o,
  output icd_pkg::cond_code_t      cond_code_o
);
  import icd_pkg::*;

  inst_class_t wide_cls;
  inst_class_t narrow_cls;
  logic [3:0]  low_nib;
  logic [15:8] h;

  assign low_nib = instruction_i[7:4];
  assign h       = instruction_i[15:8];

  // 32-bit set, priority order
  always_comb begin
    case (instruction_i[27:26])
      2'd0: begin
        if (instruction_i[27:4] == BxPattern) begin
          wide_cls = ClsBx;
        end else if (instruction_i[25:22] == 4'd0 && low_nib == MulNibble) begin
          wide_cls = ClsMul;
        end else if (instruction_i[25:23] == SwpOp && instruction_i[21:20] == 2'd0 &&
                     instruction_i[11:4] == {4'd0, MulNibble}) begin
          wide_cls = ClsSwp;
        end else if (instruction_i[25:23] == MullOp && low_nib == MulNibble) begin
          wide_cls = ClsMull;
        end else if (low_nib[3] && low_nib[0] && low_nib != MulNibble &&
                     instruction_i[27:25] == 3'd0) begin
          wide_cls = ClsHalfXfer;
        end else begin
          wide_cls = ClsDataProc;
        end
      end
      2'd1:    wide_cls = ClsSingleXfer;
      2'd2:    wide_cls = instruction_i[25] ? ClsBranch : ClsBlockXfer;
      default: wide_cls = ClsSwi;
    endcase
  end

  // 16-bit set, split on bits 15:13
  always_comb begin
    case (h[15:13])
      3'd0: narrow_cls = (h[12:11] == 2'b11) ? ClsTAddSub : ClsTMovShift;
      3'd1: narrow_cls = ClsTImm;
      3'd2: begin
        if (h[12]) begin
          narrow_cls = h[9] ? ClsTSignExt : ClsTRegOff;
        end else if (h[11]) begin
          narrow_cls = ClsTPcLoad;
        end else begin
          narrow_cls = h[10] ? ClsTHiReg : ClsTAlu;
        end
      end
      3'd3: narrow_cls = ClsTImmOff;
      3'd4: narrow_cls = h[12] ? ClsTSpRel : ClsTHalf;
      3'd5: begin
        if (h[12]) begin
          narrow_cls = (h[11:8] == 4'h0) ? ClsTSpAdd : ClsTPushPop;
        end else begin
          narrow_cls = ClsTLoadAddr;
        end
      end
      3'd6: begin
        if (h[12]) begin
          narrow_cls = (h[11:8] == 4'hf) ? ClsTSwi : ClsTCondBr;
        end else begin
          narrow_cls = ClsTMultiple;
        end
      end
      default: narrow_cls = h[12] ? ClsTLongBr : ClsTBranch;
    endcase
  end

  always_comb begin
    if (instruction_i == 32'd0) begin
      inst_class_o = ClsBubble;
    end else if (thumb_mode_i) begin
      inst_class_o = narrow_cls;
    end else begin
      inst_class_o = wide_cls;
    end
  end

  assign cond_code_o = thumb_mode_i ? CondAlways : instruction_i[31:28];

endmodule

@@ design/instruction_class_decoder_top.sv @@
// Instruction class decoder.
//
// Command channel: drive instruction_i and thumb_mode_i with start_i high for
// one cycle; the transaction is taken at the rising edge where start_i is high
// and busy_o is low. busy_o is held low, so a new transaction can be issued
// every cycle.
//
// Result channel: inst_class_o and cond_code_o are valid for exactly one cycle
// while done_o is high. The receiver cannot stall; results must be taken when
// shown.
//
// Path: an accepted transaction goes through the input register, then through
// the decode logic into the result register.
// Throughput: 1 transaction per cycle, set by the single decode stage.
//
// Reset (rst_ni low, asynchronous) clears both stage valid flags, dropping any
// transaction in flight; done_o is low during and right after reset.
module instruction_class_decoder_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [31:0]          instruction_i,
  input  logic                 thumb_mode_i,
  output logic                 done_o,
  output icd_pkg::inst_class_t inst_class_o,
  output icd_pkg::cond_code_t  cond_code_o
);
  import icd_pkg::*;

  // Input stage
  logic        in_valid_q;
  logic [31:0] instr_q;
  logic        thumb_q;

  // Result stage
  logic        done_q;
  inst_class_t class_q;
  inst_class_t class_d;
  cond_code_t  cond_q;
  cond_code_t  cond_d;

  logic        accept;

  // Pure pipeline with no backpressure: never busy.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_valid_q <= accept;
      done_q     <= in_valid_q;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      instr_q <= instruction_i;
      thumb_q <= thumb_mode_i;
    end
    if (in_valid_q) begin
      class_q <= class_d;
      cond_q  <= cond_d;
    end
  end

  icd_decode u_decode (
    .instruction_i (instr_q),
    .thumb_mode_i  (thumb_q),
    .inst_class_o  (class_d),
    .cond_code_o   (cond_d)
  );

  assign done_o       = done_q;
  assign inst_class_o = class_q;
  assign cond_code_o  = cond_q;

endmodule
